>>> rtl/pgd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_pkg
// Shared types and constants of the 2x2 point grid downsampler.
// ----------------------------------------------------------------------------
package pgd_pkg;

  localparam int unsigned MaxWidth    = 1024;
  localparam int unsigned HeightLimit = 4096;
  localparam int unsigned ColW        = $clog2(MaxWidth);
  localparam int unsigned RowW        = $clog2(HeightLimit);
  localparam int unsigned CfgWidthW   = 11;
  localparam int unsigned CfgHeightW  = 13;
  localparam int unsigned LimitW      = 62;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);

  // register indexes
  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [31:0]        color;
    logic               valid;
  } point_t;

  // one full cell handed from front to back
  typedef struct packed {
    point_t p0;
    point_t p1;
    point_t p2;
    point_t p3;
    logic   frame_end;
  } cell_t;

  // back-end phase sequence
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SQUARE,
    BK_SUM,
    BK_DIVIDE,
    BK_OUT
  } back_state_e;

endpackage

>>> rtl/pgd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_front
// Tracks raster position, keeps the even row in a line store and assembles
// a 2x2 cell on each odd-row, odd-column point.
// ----------------------------------------------------------------------------
module pgd_front import pgd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  output logic                  full_o,
  input  point_t                pt_i,
  input  logic [CfgWidthW-1:0]  width_i,
  input  logic [CfgHeightW-1:0] height_i,
  output logic                  cell_valid_o,
  output cell_t                 cell_o,
  input  logic                  cell_ready_i
);

  logic [ColW-1:0]   col_q, col_d;
  logic [RowW-1:0]   row_q, row_d;
  logic [CfgWidthW:0]  w_eff;
  logic [CfgHeightW:0] h_eff;
  logic              acc;
  point_t            line_q [MaxWidth];
  point_t            rd_a_q, rd_b_q, held_q, cur_q;
  logic              pend_q, fe_q;
  logic              is_fire;
  logic              fe_now;

  // effective geometry, clamped
  always_comb begin
    if (width_i < CfgWidthW'(2)) w_eff = (CfgWidthW+1)'(2);
    else if (width_i > CfgWidthW'(MaxWidth)) w_eff = (CfgWidthW+1)'(MaxWidth);
    else w_eff = {1'b0, width_i};
    if (height_i < CfgHeightW'(2)) h_eff = (CfgHeightW+1)'(2);
    else if (height_i > CfgHeightW'(HeightLimit)) h_eff = (CfgHeightW+1)'(HeightLimit);
    else h_eff = {1'b0, height_i};
  end

  assign full_o  = pend_q && !cell_ready_i;
  assign acc     = push_i && !full_o;
  assign is_fire = row_q[0] && col_q[0];
  assign fe_now  = ({1'b0, row_q} == (CfgHeightW+1)'({h_eff[CfgHeightW:1], 1'b0} - 1'b1))
                && ({1'b0, col_q} == (CfgWidthW+1)'({w_eff[CfgWidthW:1], 1'b0} - 1'b1));

  // position counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (acc) begin
      if ({1'b0, col_q} + (CfgWidthW+1)'(1) >= w_eff) begin
        col_d = '0;
        row_d = ({1'b0, row_q} + (CfgHeightW+1)'(1) >= h_eff) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (acc) pend_q <= is_fire;
      else if (cell_ready_i) pend_q <= 1'b0;
    end
  end

  // line store and held point
  always_ff @(posedge clk_i) begin
    if (acc) begin
      if (!row_q[0]) line_q[col_q] <= pt_i;
      else if (!col_q[0]) held_q <= pt_i;
      else begin
        rd_a_q <= line_q[col_q - 1'b1];
        rd_b_q <= line_q[col_q];
        cur_q  <= pt_i;
        fe_q   <= fe_now;
      end
    end
  end

  assign cell_valid_o = pend_q;
  assign cell_o = '{p0: rd_a_q, p1: rd_b_q, p2: held_q, p3: cur_q, frame_end: fe_q};

endmodule

>>> rtl/pgd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_queue
// Short cell queue between the front and back ends.
// ----------------------------------------------------------------------------
module pgd_queue import pgd_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  wr_i,
  output logic  wr_ready_o,
  input  cell_t wr_data_i,
  output logic  rd_valid_o,
  input  logic  rd_i,
  output cell_t rd_data_o
);

  cell_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wp_q, rp_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 do_wr, do_rd;

  assign wr_ready_o = cnt_q != (QueuePtrW+1)'(QueueDepth);
  assign rd_valid_o = cnt_q != '0;
  assign do_wr      = wr_i && wr_ready_o;
  assign do_rd      = rd_i && rd_valid_o;
  assign rd_data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wp_q] <= wr_data_i;
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_wr) wp_q <= wp_q + 1'b1;
      if (do_rd) rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(do_wr) - (QueuePtrW+1)'(do_rd);
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QueuePtrW+1)'(QueueDepth)) else $error("queue overflow");
  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count step");
  a_rd_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> !rd_valid_o) else $error("read from empty");
`endif

endmodule

>>> rtl/pgd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgd_back
// Computes the distance test, masked sums and rounded mean of one cell, and
// holds the result for the output side.
// ----------------------------------------------------------------------------
module pgd_back import pgd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cell_valid_i,
  output logic              cell_pop_o,
  input  cell_t             cell_i,
  input  logic [LimitW-1:0] limit_i,
  output logic              empty_o,
  input  logic              pop_i,
  output point_t            res_o,
  output logic              frame_end_o
);

  back_state_e st_q, st_d;
  cell_t       c_q;
  point_t      pts [4];
  logic [1:0]  idx_q;
  logic [2:0]  cnt_q;
  logic [63:0] acc_q;
  logic [1:0]  ax_q;
  logic [63:0] sq;
  logic [33:0] sx_q, sy_q, sz_q;
  logic [3:0]  keep_q;
  logic signed [32:0] diff;
  logic [32:0] mag;
  logic signed [31:0] av, pv;
  logic signed [33:0] sum_sel;
  logic [33:0] m_abs;
  logic [34:0] num;
  logic [32:0] q_div;
  logic [31:0] qo;
  point_t      out_q;
  logic        fe_q;
  point_t      res_q;
  logic        res_fe_q;
  logic        full_q;
  logic [64:0] acc_sum;

  assign pts[0] = c_q.p0;
  assign pts[1] = c_q.p1;
  assign pts[2] = c_q.p2;
  assign pts[3] = c_q.p3;

  // one axis difference squared per cycle
  always_comb begin
    unique case (ax_q)
      2'd0:    begin av = c_q.p0.x; pv = pts[idx_q].x; end
      2'd1:    begin av = c_q.p0.y; pv = pts[idx_q].y; end
      default: begin av = c_q.p0.z; pv = pts[idx_q].z; end
    endcase
    diff = 33'(av) - 33'(pv);
    mag  = diff[32] ? 33'(-diff) : 33'(diff);
  end
  assign sq      = 64'(mag[31:0]) * 64'(mag[31:0]) + (mag[32] ? 64'hFFFF_FFFF_FFFF_FFFF : '0);
  assign acc_sum = 65'(acc_q) + 65'(sq);

  // rounded division by count (1..4) of one sum
  always_comb begin
    unique case (ax_q)
      2'd0:    sum_sel = sx_q;
      2'd1:    sum_sel = sy_q;
      default: sum_sel = sz_q;
    endcase
    m_abs = sum_sel[33] ? 34'(-sum_sel) : 34'(sum_sel);
    num   = 35'(m_abs) + 35'(cnt_q >> 1);
    unique case (cnt_q)
      3'd1:    q_div = 33'(num);
      3'd2:    q_div = 33'(num >> 1);
      // exact reciprocal of three for any numerator below 2^33
      3'd3:    q_div = 33'((66'(num[32:0]) * 66'h1_5555_5556) >> 34);
      default: q_div = 33'(num >> 2);
    endcase
    qo = sum_sel[33] ? 32'(-q_div) : q_div[31:0];
  end

  // state sequence
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      BK_IDLE:   if (cell_valid_i) st_d = BK_SQUARE;
      BK_SQUARE: if (ax_q == 2'd2 && idx_q == 2'd3) st_d = BK_SUM;
      BK_SUM:    st_d = BK_DIVIDE;
      BK_DIVIDE: if (ax_q == 2'd2) st_d = BK_OUT;
      BK_OUT:    if (!full_q) st_d = BK_IDLE;
      default:   st_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cell_pop_o = (st_q == BK_IDLE) && cell_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= BK_IDLE;
      full_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (st_q == BK_OUT && !full_q) full_q <= 1'b1;
      else if (pop_i && full_q) full_q <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      BK_IDLE: begin
        c_q   <= cell_i;
        idx_q <= '0;
        ax_q  <= '0;
        acc_q <= '0;
      end
      BK_SQUARE: begin
        if (ax_q == 2'd2) begin
          keep_q[idx_q] <= pts[idx_q].valid && c_q.p0.valid && !acc_sum[64]
                           && (acc_sum[63:0] < 64'(limit_i));
          acc_q <= '0;
          ax_q  <= '0;
          idx_q <= idx_q + 1'b1;
        end else begin
          acc_q <= acc_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : acc_sum[63:0];
          ax_q  <= ax_q + 1'b1;
        end
      end
      BK_SUM: begin
        sx_q  <= (keep_q[0] ? 34'(c_q.p0.x) : '0) + (keep_q[1] ? 34'(c_q.p1.x) : '0)
               + (keep_q[2] ? 34'(c_q.p2.x) : '0) + (keep_q[3] ? 34'(c_q.p3.x) : '0);
        sy_q  <= (keep_q[0] ? 34'(c_q.p0.y) : '0) + (keep_q[1] ? 34'(c_q.p1.y) : '0)
               + (keep_q[2] ? 34'(c_q.p2.y) : '0) + (keep_q[3] ? 34'(c_q.p3.y) : '0);
        sz_q  <= (keep_q[0] ? 34'(c_q.p0.z) : '0) + (keep_q[1] ? 34'(c_q.p1.z) : '0)
               + (keep_q[2] ? 34'(c_q.p2.z) : '0) + (keep_q[3] ? 34'(c_q.p3.z) : '0);
        cnt_q <= 3'(keep_q[0]) + 3'(keep_q[1]) + 3'(keep_q[2]) + 3'(keep_q[3]);
        ax_q  <= '0;
        out_q <= c_q.p0;
        fe_q  <= c_q.frame_end;
      end
      BK_DIVIDE: begin
        if (cnt_q != '0) begin
          unique case (ax_q)
            2'd0:    out_q.x <= qo;
            2'd1:    out_q.y <= qo;
            default: out_q.z <= qo;
          endcase
        end
        ax_q <= ax_q + 1'b1;
      end
      BK_OUT: begin
        // result register, free once the previous beat has left
        if (!full_q) begin
          res_q    <= out_q;
          res_fe_q <= fe_q;
        end
      end
      default: ;
    endcase
  end

  assign empty_o     = !full_q;
  assign res_o       = res_q;
  assign frame_end_o = res_fe_q;

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cell_pop_o |-> st_q == BK_IDLE) else $error("pop while busy");
  a_out_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == BK_OUT && full_q) |=> st_q == BK_OUT || !$past(full_q)) else $error("out lost");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == BK_DIVIDE |-> cnt_q <= 3'd4) else $error("bad count");
`endif

endmodule

>>> rtl/point_grid_downsample_2x2_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_grid_downsample_2x2_top
// 2x2 point grid downsampler with distance-gated local mean.
// ----------------------------------------------------------------------------
// Points are taken one per cycle whenever full_o is low; even rows only fill
// the line store, so most points finish at once. Each cell (one per two
// points of an odd row) is worked by the back end in order: load, the
// one-multiplier distance test, one sum, three divides and output. A four
// entry queue absorbs bursts; a new cell is taken only once the last
// result is registered. The line store has no clearing pass and no reset.
module point_grid_downsample_2x2_top import pgd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [31:0] x_in_i,
  input  logic signed [31:0] y_in_i,
  input  logic signed [31:0] z_in_i,
  input  logic [31:0]        color_in_i,
  input  logic               valid_in_i,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] x_out_o,
  output logic signed [31:0] y_out_o,
  output logic signed [31:0] z_out_o,
  output logic [31:0]        color_out_o,
  output logic               valid_out_o,
  output logic               frame_end_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [CfgWidthW-1:0]  width_q;
  logic [CfgHeightW-1:0] height_q;
  logic [LimitW-1:0]     limit_q;
  logic                  wr_en;
  logic [1:0]            reg_sel;
  point_t                pt_in, res;
  logic                  fc_valid, fc_ready, qv, qpop;
  cell_t                 fc, qc;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = paddr[4:3];

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CfgWidthW'(640);
      height_q <= CfgHeightW'(480);
      limit_q  <= '0;
    end else if (wr_en && paddr[2:0] == 3'd0) begin
      unique case (reg_sel)
        REG_WIDTH:  width_q  <= pwdata[CfgWidthW-1:0];
        REG_HEIGHT: height_q <= pwdata[CfgHeightW-1:0];
        REG_LIMIT:  limit_q  <= pwdata[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  prdata = 64'(width_q);
      REG_HEIGHT: prdata = 64'(height_q);
      REG_LIMIT:  prdata = 64'(limit_q);
      default:    prdata = '0;
    endcase
  end

  assign pt_in = '{x: x_in_i, y: y_in_i, z: z_in_i, color: color_in_i, valid: valid_in_i};

  pgd_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .pt_i(pt_in),
    .width_i(width_q), .height_i(height_q),
    .cell_valid_o(fc_valid), .cell_o(fc), .cell_ready_i(fc_ready)
  );

  pgd_queue u_queue (
    .clk_i, .rst_ni, .wr_i(fc_valid), .wr_ready_o(fc_ready), .wr_data_i(fc),
    .rd_valid_o(qv), .rd_i(qpop), .rd_data_o(qc)
  );

  pgd_back u_back (
    .clk_i, .rst_ni, .cell_valid_i(qv), .cell_pop_o(qpop), .cell_i(qc),
    .limit_i(limit_q), .empty_o(empty), .pop_i(pop), .res_o(res),
    .frame_end_o(frame_end_o)
  );

  assign x_out_o     = res.x;
  assign y_out_o     = res.y;
  assign z_out_o     = res.z;
  assign color_out_o = res.color;
  assign valid_out_o = res.valid;

endmodule
